### sv/bdq_pkg.sv
`default_nettype none
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int CMD_W = 3;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd5;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  // per-cell move control for the current cycle
  typedef struct packed {
    logic load_new;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### sv/bdq_cell.sv
`default_nettype none
module bdq_cell
  import bdq_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [VAL_W-1:0] new_val,
  input  wire logic [VAL_W-1:0] left_val,
  input  wire logic [VAL_W-1:0] right_val,
  input  wire logic [VAL_W-1:0] key,
  input  wire logic             live,
  output logic      [VAL_W-1:0] data,
  output logic                  hit
);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load_new) begin
      data_nxt = new_val;
    end else if (ctrl.take_left) begin
      data_nxt = left_val;
    end else if (ctrl.take_right) begin
      data_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = live && (data_r == key);

endmodule
`default_nettype wire

### sv/bounded_deque_with_insert_search.sv
`default_nettype none
// bounded deque with positional insert and search
//
// input channel: in_valid/in_ready carry one command item (in_command,
// in_value, in_position). result channel: out_valid/out_ready carry one
// result item per command (out_status, out_found, out_found_index,
// out_count).
//
// storage is a row of DEPTH entry cells. every inner cell sees both neighbors,
// so push front and insert shift the tail back one place, and pop front
// shifts everything forward one place, all at once. search
// compares the key in every live cell at once and a priority encoder picks
// the lowest matching index.
// the result is registered, available in the cycle after the item is
// accepted. throughput: one item per cycle while the receiver keeps the
// result register drained, set by the shift/compare of the cell row.
// receiver stall: a new item is taken whenever the result register is
// empty or being drained the same cycle; otherwise in_ready drops.
// reset (rst_n low, synchronous) empties the store and the result
// register; entry contents are not cleared and are never read unwritten
module bounded_deque_with_insert_search
  import bdq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic        [CMD_W-1:0] in_command,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire logic        [CNT_W-1:0] in_position,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic             [ST_W-1:0]  out_status,
  output logic                         out_found,
  output logic             [IDX_W-1:0] out_found_index,
  output logic             [CNT_W-1:0] out_count
);

  logic             in_fire;

  // fill state
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             full;
  logic             empty;

  // decoded command
  logic             ins_en;
  logic [CNT_W-1:0] ins_pos;
  logic             del_en;
  logic [ST_W-1:0]  status;
  logic             found;
  logic [IDX_W-1:0] found_idx;

  // cell row
  cell_ctrl_t       ctrl [DEPTH];
  logic [VAL_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] live;
  logic [DEPTH-1:0] hit;

  // result register
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [ST_W-1:0]  status_r;
  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic [CNT_W-1:0] out_count_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // command decode: push front/back are inserts at the ends
  always_comb begin
    ins_en    = 1'b0;
    ins_pos   = '0;
    del_en    = 1'b0;
    status    = ST_OK;
    count_nxt = count_r;
    case (in_command)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ins_en    = 1'b1;
          ins_pos   = '0;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ins_en    = 1'b1;
          ins_pos   = count_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          del_en    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (in_position == '0 || in_position > count_r) begin
          status = ST_BADPOS;
        end else begin
          // position equal to count lands at the back, same as an append
          ins_en    = 1'b1;
          ins_pos   = in_position;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      default: begin
        // search and unused codes leave the store alone
      end
    endcase
  end

  // per-cell control, gated by the handshake
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].load_new   = in_fire && ins_en && (CNT_W'(i) == ins_pos);
      ctrl[i].take_left  = in_fire && ins_en && (CNT_W'(i) > ins_pos);
      ctrl[i].take_right = in_fire && del_en;
      live[i]            = (CNT_W'(i) < count_r);
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [VAL_W-1:0] left_val;
      logic [VAL_W-1:0] right_val;

      // front cell never shifts in from the left; last cell keeps its own
      if (g == 0) begin : g_front
        assign left_val = in_value;
      end else begin : g_mid_l
        assign left_val = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_back
        assign right_val = cell_data[g];
      end else begin : g_mid_r
        assign right_val = cell_data[g+1];
      end

      bdq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl[g]),
        .new_val   (in_value),
        .left_val  (left_val),
        .right_val (right_val),
        .key       (in_value),
        .live      (live[g]),
        .data      (cell_data[g]),
        .hit       (hit[g])
      );
    end
  endgenerate

  // first match wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    if (in_command == CMD_SEARCH) begin
      for (int i = DEPTH - 1; i >= 0; i--) begin
        if (hit[i]) begin
          found     = 1'b1;
          found_idx = IDX_W'(i);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r    <= status;
      found_r     <= found;
      found_idx_r <= found_idx;
      out_count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found       = found_r;
  assign out_found_index = found_idx_r;
  assign out_count       = out_count_r;

endmodule
`default_nettype wire

### sv/bdq_checker.sv
`default_nettype none
module bdq_checker
  import bdq_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic        [CMD_W-1:0] in_command,
  input wire logic signed [VAL_W-1:0] in_value,
  input wire logic        [CNT_W-1:0] in_position,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic        [ST_W-1:0]  out_status,
  input wire logic                    out_found,
  input wire logic        [IDX_W-1:0] out_found_index,
  input wire logic        [CNT_W-1:0] out_count
);

  // result register empties on reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_status))
    else $error("stalled result changed");

  // a hit only comes with ok status and fits the fill
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK && {1'b0, out_found_index} < out_count)
    else $error("found with bad status or index");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_index == '0)
    else $error("index nonzero on miss");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(DEPTH))
    else $error("count above depth");

endmodule

bind bounded_deque_with_insert_search bdq_checker u_bdq_checker (.*);
`default_nettype wire

### test/bounded_deque_with_insert_search_test.sv
`default_nettype none
module bounded_deque_with_insert_search_test;
  import bdq_pkg::*;

  // the two command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // one result item as the block reports it
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] count;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic        [CMD_W-1:0] in_command = CMD_SEARCH;
  logic signed [VAL_W-1:0] in_value = '0;
  logic        [CNT_W-1:0] in_position = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic        [ST_W-1:0]  out_status;
  logic                    out_found;
  logic        [IDX_W-1:0] out_found_index;
  logic        [CNT_W-1:0] out_count;

  // shadow copy of the store, updated as each item is accepted
  logic signed [VAL_W-1:0] shadow_entries [DEPTH];
  int unsigned             shadow_fill = 0;

  // results still owed by the block, oldest first
  deque_result_t expected_results [$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  // when set, neither side idles
  bit          steady_flow = 1'b0;
  int unsigned stall_left = 0;
  // random traffic leans toward filling or draining the store
  bit          filling = 1'b1;

  bounded_deque_with_insert_search DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_found_index (out_found_index),
    .out_count       (out_count)
  );

  always #5 clk = ~clk;

  // hard stop in case the handshake hangs
  initial begin
    #5_000_000;
    $display("[bounded_deque_with_insert_search] ERROR");
    $finish;
  end

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // apply one command to the shadow store and return what the block must report
  function automatic deque_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [VAL_W-1:0] val,
                                                  input logic [CNT_W-1:0] pos);
    deque_result_t r;
    int unsigned i;
    bit hit;
    r = '0;
    hit = 1'b0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_fill; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[0] = val;
          shadow_fill++;
        end
      end
      CMD_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_fill] = val;
          shadow_fill++;
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < shadow_fill; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_fill--;
        end
      end
      CMD_POP_BACK: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else shadow_fill--;
      end
      CMD_INSERT: begin
        // a full store wins over a bad position
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else if (pos == 0 || pos > shadow_fill) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = shadow_fill; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = val;
          shadow_fill++;
        end
      end
      CMD_SEARCH: begin
        // first match from the front wins
        for (i = 0; i < shadow_fill; i++) begin
          if (!hit && shadow_entries[i] == val) begin
            hit = 1'b1;
            r.found = 1'b1;
            r.found_index = i[IDX_W-1:0];
          end
        end
      end
      default: ;
    endcase
    r.count = shadow_fill[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
    mismatch_count++;
  endtask

  // present one item, hold it until taken, then record the expected result
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic signed [VAL_W-1:0] val,
                           input logic [CNT_W-1:0] pos);
    int unsigned gap;
    deque_result_t want;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_value    <= val;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    want = apply_command(cmd, val, pos);
    expected_results = {expected_results, want};
  endtask

  // stop sending until every owed result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // receiver side: ready with occasional stalls of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady_flow && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // compare each result item against the oldest expectation
  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", {30'd0, out_status}, 32'd0);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_status !== want.status)
          report_mismatch("status", {30'd0, out_status}, {30'd0, want.status});
        if (out_found !== want.found)
          report_mismatch("found", {31'd0, out_found}, {31'd0, want.found});
        if (out_found_index !== want.found_index)
          report_mismatch("found_index", {28'd0, out_found_index}, {28'd0, want.found_index});
        if (out_count !== want.count)
          report_mismatch("count", {27'd0, out_count}, {27'd0, want.count});
      end
      results_seen++;
    end
  end

  // value source: a small pool so searches hit, live entries, extremes, anything
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $signed($urandom_range(0, 7)) - 4;
    if (r < 65 && shadow_fill != 0) return shadow_entries[$urandom_range(0, shadow_fill - 1)];
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MAX;
        1:       return VAL_MIN;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  // insert position: mostly legal, some just outside, some anything
  function automatic logic [CNT_W-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75 && shadow_fill != 0) return CNT_W'($urandom_range(1, shadow_fill));
    if (r < 85) return ($urandom_range(0, 1) != 0) ? CNT_W'(shadow_fill + 1) : '0;
    return CNT_W'($urandom_range(0, 31));
  endfunction

  // pops, searches and no-ops on the empty store, plus an insert past the fill
  task automatic test_empty_store();
    send_item(CMD_POP_FRONT, VAL_MAX, '0);
    send_item(CMD_POP_BACK, VAL_MIN, 5'd31);
    send_item(CMD_SEARCH, '0, '0);
    send_item(CMD_INSERT, 32'sd5, 5'd1);
    send_item(CMD_SPARE_7, -1, 5'd31);
  endtask

  // build a short list and probe insert edges and search
  task automatic test_build_and_search();
    send_item(CMD_PUSH_BACK, VAL_MAX, '0);
    send_item(CMD_PUSH_FRONT, VAL_MIN, '0);
    // insert at the current count acts as an append
    send_item(CMD_INSERT, -1, 5'd2);
    send_item(CMD_INSERT, '0, 5'd1);
    // one past the count is rejected
    send_item(CMD_INSERT, 32'sd9, 5'd5);
    send_item(CMD_INSERT, 32'sd9, 5'd0);
    send_item(CMD_SEARCH, -1, '0);
    send_item(CMD_SPARE_6, 32'sh5a5a_5a5a, 5'd16);
  endtask

  // fill to the limit, then everything that needs room is refused
  task automatic test_full_store();
    while (shadow_fill < DEPTH)
      send_item(CMD_PUSH_BACK, (shadow_fill % 3 == 0) ? 0 : shadow_fill, '0);
    send_item(CMD_PUSH_FRONT, 32'sd1, '0);
    send_item(CMD_PUSH_BACK, 32'sd1, '0);
    // full is reported ahead of a bad position
    send_item(CMD_INSERT, 32'sd1, 5'd0);
    send_item(CMD_INSERT, 32'sd1, 5'd31);
    // duplicates: the earliest index is reported
    send_item(CMD_SEARCH, '0, '0);
    send_item(CMD_SEARCH, shadow_entries[DEPTH-1], '0);
    send_item(CMD_SEARCH, 32'sh1234_5678, '0);
  endtask

  // mixed traffic that sweeps between empty and full
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned k;
    int unsigned r;
    logic [CMD_W-1:0] cmd;
    for (k = 0; k < n_items; k++) begin
      if (shadow_fill >= DEPTH) filling = 1'b0;
      else if (shadow_fill == 0) filling = 1'b1;
      else if ($urandom_range(0, 39) == 0) filling = ~filling;
      r = $urandom_range(0, 99);
      if (r < 5)       cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      else if (r < 25) cmd = CMD_SEARCH;
      else if ((r < 75) == filling) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_PUSH_FRONT;
          1:       cmd = CMD_PUSH_BACK;
          default: cmd = CMD_INSERT;
        endcase
      end else begin
        cmd = ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
      end
      send_item(cmd, pick_value(), pick_position());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_build_and_search();
    test_full_store();
    wait_for_results();

    test_random_traffic(700);
    wait_for_results();

    // back to back with no idling on either side
    steady_flow = 1'b1;
    test_random_traffic(200);
    wait_for_results();
    steady_flow = 1'b0;

    test_random_traffic(200);
    wait_for_results();

    // allow for any stray result after the last expected one
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[bounded_deque_with_insert_search] OK");
    end else begin
      $display("[bounded_deque_with_insert_search] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
